// File: sv/hng_pkg.sv
`default_nettype none
package hng_pkg;

  // Payload widths
  localparam int COL_W      = 10;
  localparam int ROW_W      = 12;
  localparam int H_W        = 16;
  localparam int N_W        = 16;
  localparam int NY_W       = 15;
  localparam int OUT_DATA_W = 88;
  localparam int CFG_RW_W   = 11;
  localparam int CFG_RC_W   = 13;
  localparam int SUM_W      = 34;

  // Default geometry limits
  localparam int DEF_MAX_ROW_WIDTH = 1024;
  localparam int DEF_MAX_ROW_COUNT = 4096;
  localparam logic [CFG_RW_W-1:0] RST_ROW_WIDTH = CFG_RW_W'(1024);
  localparam logic [CFG_RC_W-1:0] RST_ROW_COUNT = CFG_RC_W'(1024);

  // Register map, selected by paddr[2]
  localparam logic REG_ROW_WIDTH = 1'b0;
  localparam logic REG_ROW_COUNT = 1'b1;

  // Up vector constant 2.0 in Q8.8 and its square
  localparam logic [15:0]      TWO_Q88 = 16'd512;
  localparam logic [SUM_W-1:0] TWO_SQ  = SUM_W'(262144);

  // Store read slots
  localparam logic [1:0] RD_CUR   = 2'd0;
  localparam logic [1:0] RD_NEXT  = 2'd1;
  localparam logic [1:0] RD_PREV  = 2'd2;
  localparam logic [1:0] RD_PREV2 = 2'd3;

  // Vertex kinds emitted per sample
  localparam logic [1:0] EMIT_BELOW = 2'd0;
  localparam logic [1:0] EMIT_LEFT  = 2'd1;
  localparam logic [1:0] EMIT_LAST  = 2'd2;

  // Normal components
  localparam logic [1:0] COMP_X = 2'd0;
  localparam logic [1:0] COMP_Y = 2'd1;
  localparam logic [1:0] COMP_Z = 2'd2;

  typedef struct packed {
    logic       take;
    logic       rd_en;
    logic [1:0] rd_step;
    logic       cap_en;
    logic [1:0] cap_step;
    logic       wr_en;
    logic       load_emit;
    logic [1:0] emit_sel;
    logic       sq_x;
    logic       sq_z;
    logic       sum;
    logic [1:0] comp;
    logic       div_init;
    logic       div_step;
    logic       sqrt_init;
    logic       sqrt_step;
    logic       store;
    logic       out_load;
    logic       adv;
  } hng_cmd_t;

  typedef struct packed {
    logic [2:0] need;      // bit per emit kind
    logic       out_busy;
  } hng_stat_t;

endpackage
`default_nettype wire

// File: sv/hng_ram.sv
`default_nettype none
module hng_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// File: sv/hng_ctrl.sv
`default_nettype none
module hng_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire hng_pkg::hng_stat_t stat,
  output hng_pkg::hng_cmd_t      cmd
);
  import hng_pkg::*;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_RD0  = 4'd1;
  localparam logic [3:0] ST_RD1  = 4'd2;
  localparam logic [3:0] ST_RD2  = 4'd3;
  localparam logic [3:0] ST_RD3  = 4'd4;
  localparam logic [3:0] ST_RD4  = 4'd5;
  localparam logic [3:0] ST_WR   = 4'd6;
  localparam logic [3:0] ST_PICK = 4'd7;
  localparam logic [3:0] ST_SQX  = 4'd8;
  localparam logic [3:0] ST_SQZ  = 4'd9;
  localparam logic [3:0] ST_SUM  = 4'd10;
  localparam logic [3:0] ST_DIVI = 4'd11;
  localparam logic [3:0] ST_DIV  = 4'd12;
  localparam logic [3:0] ST_SQI  = 4'd13;
  localparam logic [3:0] ST_SQ   = 4'd14;
  localparam logic [3:0] ST_STO  = 4'd15;
  localparam logic [4:0] DIV_LAST  = 5'd30;
  localparam logic [4:0] SQRT_LAST = 5'd15;

  logic [3:0] state_r, state_nxt;
  logic [2:0] pend_r, pend_nxt;
  logic [1:0] comp_r, comp_nxt;
  logic [4:0] cnt_r, cnt_nxt;
  logic       outw_r, outw_nxt;   // waiting for the output slot after STO

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      pend_r  <= '0;
      comp_r  <= COMP_X;
      cnt_r   <= '0;
      outw_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pend_r  <= pend_nxt;
      comp_r  <= comp_nxt;
      cnt_r   <= cnt_nxt;
      outw_r  <= outw_nxt;
    end
  end

  assign in_tready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    pend_nxt  = pend_r;
    comp_nxt  = comp_r;
    cnt_nxt   = cnt_r;
    outw_nxt  = outw_r;
    cmd       = '0;
    cmd.comp  = comp_r;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.take  = 1'b1;
          state_nxt = ST_RD0;
        end
      end
      ST_RD0: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_step = RD_CUR;
        state_nxt   = ST_RD1;
      end
      ST_RD1: begin
        cmd.rd_en    = 1'b1;
        cmd.rd_step  = RD_NEXT;
        cmd.cap_en   = 1'b1;
        cmd.cap_step = RD_CUR;
        state_nxt    = ST_RD2;
      end
      ST_RD2: begin
        cmd.rd_en    = 1'b1;
        cmd.rd_step  = RD_PREV;
        cmd.cap_en   = 1'b1;
        cmd.cap_step = RD_NEXT;
        state_nxt    = ST_RD3;
      end
      ST_RD3: begin
        cmd.rd_en    = 1'b1;
        cmd.rd_step  = RD_PREV2;
        cmd.cap_en   = 1'b1;
        cmd.cap_step = RD_PREV;
        state_nxt    = ST_RD4;
      end
      ST_RD4: begin
        cmd.cap_en   = 1'b1;
        cmd.cap_step = RD_PREV2;
        state_nxt    = ST_WR;
      end
      ST_WR: begin
        cmd.wr_en = 1'b1;
        pend_nxt  = stat.need;
        state_nxt = ST_PICK;
      end
      ST_PICK: begin
        if (pend_r == 3'b000) begin
          cmd.adv   = 1'b1;
          state_nxt = ST_IDLE;
        end else begin
          cmd.load_emit = 1'b1;
          if (pend_r[0]) begin
            cmd.emit_sel = EMIT_BELOW;
            pend_nxt     = {pend_r[2:1], 1'b0};
          end else if (pend_r[1]) begin
            cmd.emit_sel = EMIT_LEFT;
            pend_nxt     = {pend_r[2], 2'b00};
          end else begin
            cmd.emit_sel = EMIT_LAST;
            pend_nxt     = 3'b000;
          end
          state_nxt = ST_SQX;
        end
      end
      ST_SQX: begin
        cmd.sq_x  = 1'b1;
        state_nxt = ST_SQZ;
      end
      ST_SQZ: begin
        cmd.sq_z  = 1'b1;
        state_nxt = ST_SUM;
      end
      ST_SUM: begin
        cmd.sum   = 1'b1;
        comp_nxt  = COMP_X;
        state_nxt = ST_DIVI;
      end
      ST_DIVI: begin
        cmd.div_init = 1'b1;
        cnt_nxt      = '0;
        state_nxt    = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 5'd1;
        if (cnt_r == DIV_LAST) begin
          state_nxt = ST_SQI;
        end
      end
      ST_SQI: begin
        cmd.sqrt_init = 1'b1;
        cnt_nxt       = '0;
        state_nxt     = ST_SQ;
      end
      ST_SQ: begin
        cmd.sqrt_step = 1'b1;
        cnt_nxt       = cnt_r + 5'd1;
        if (cnt_r == SQRT_LAST) begin
          state_nxt = ST_STO;
        end
      end
      ST_STO: begin
        // component store, then hold here for the output slot on the last one
        if (!outw_r) begin
          cmd.store = 1'b1;
          if (comp_r == COMP_Z) begin
            outw_nxt = 1'b1;
          end else begin
            comp_nxt  = comp_r + 2'd1;
            state_nxt = ST_DIVI;
          end
        end else if (!stat.out_busy) begin
          cmd.out_load = 1'b1;
          outw_nxt     = 1'b0;
          state_nxt    = ST_PICK;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> !stat.out_busy) else $error("output overwritten");
  a_adv_done: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.adv |-> (pend_r == 3'b000)) else $error("advance with pending vertices");
  a_div_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (cnt_r <= DIV_LAST)) else $error("divider overran");

endmodule
`default_nettype wire

// File: sv/hng_dp.sv
`default_nettype none
module hng_dp #(
  parameter int MAX_ROW_WIDTH = hng_pkg::DEF_MAX_ROW_WIDTH,
  parameter int MAX_ROW_COUNT = hng_pkg::DEF_MAX_ROW_COUNT
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire hng_pkg::hng_cmd_t                   cmd,
  output hng_pkg::hng_stat_t                       stat,
  input  wire logic [hng_pkg::CFG_RW_W-1:0]        row_width,
  input  wire logic [hng_pkg::CFG_RC_W-1:0]        row_count,
  input  wire logic [hng_pkg::H_W-1:0]             sample,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic [hng_pkg::OUT_DATA_W-1:0]           out_data,
  output logic                                     out_last
);
  import hng_pkg::*;

  localparam int XW = $clog2(MAX_ROW_WIDTH);
  localparam int YW = $clog2(MAX_ROW_COUNT);
  localparam int WW = $clog2(MAX_ROW_WIDTH + 1);
  localparam int RW = $clog2(MAX_ROW_COUNT + 1);

  // ---------------- geometry and counters
  logic [WW-1:0] w_eff;
  logic [RW-1:0] rc_eff;
  logic [XW-1:0] x_r;
  logic [YW-1:0] y_r;
  logic [XW:0]   x_plus;
  logic [YW:0]   y_plus;
  logic          x_gt0, x_ge2, has_right, y_is0, y_is1, last_row;

  always_comb begin
    if (row_width == '0) begin
      w_eff = WW'(1);
    end else if (32'(row_width) > 32'(MAX_ROW_WIDTH)) begin
      w_eff = WW'(MAX_ROW_WIDTH);
    end else begin
      w_eff = WW'(row_width);
    end
    if (row_count == '0) begin
      rc_eff = RW'(1);
    end else if (32'(row_count) > 32'(MAX_ROW_COUNT)) begin
      rc_eff = RW'(MAX_ROW_COUNT);
    end else begin
      rc_eff = RW'(row_count);
    end
  end

  assign x_plus    = {1'b0, x_r} + 1'b1;
  assign y_plus    = {1'b0, y_r} + 1'b1;
  assign x_gt0     = (x_r != '0);
  assign x_ge2     = (32'(x_r) >= 32'd2);
  assign has_right = (32'(x_plus) < 32'(w_eff));
  assign y_is0     = (y_r == '0);
  assign y_is1     = (32'(y_r) == 32'd1);
  assign last_row  = (32'(y_r) == 32'(rc_eff) - 32'd1);

  assign stat.need = {last_row && !has_right, last_row && x_gt0, !y_is0};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_r <= '0;
      y_r <= '0;
    end else if (cmd.adv) begin
      if (32'(x_plus) >= 32'(w_eff)) begin
        x_r <= '0;
        if (32'(y_plus) >= 32'(rc_eff)) begin
          y_r <= '0;
        end else begin
          y_r <= y_plus[YW-1:0];
        end
      end else begin
        x_r <= x_plus[XW-1:0];
      end
    end
  end

  // ---------------- row stores
  logic        [H_W-1:0] smp_r;
  logic        [XW-1:0]  raddr;
  logic        [H_W-1:0] mid_q, up_q;
  logic signed [H_W-1:0] rd_a_r, rd_b_r, rd_c_r, rd_d_r, rd_e_r, rd_f_r;

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      smp_r <= sample;
    end
  end

  always_comb begin
    case (cmd.rd_step)
      RD_CUR:   raddr = x_r;
      RD_NEXT:  raddr = x_r + XW'(1);
      RD_PREV:  raddr = x_r - XW'(1);
      RD_PREV2: raddr = x_r - XW'(2);
      default:  raddr = x_r;
    endcase
  end

  hng_ram #(.WIDTH(H_W), .DEPTH(MAX_ROW_WIDTH)) u_mid_ram (
    .clk  (clk),
    .we   (cmd.wr_en),
    .waddr(x_r),
    .wdata(smp_r),
    .re   (cmd.rd_en),
    .raddr(raddr),
    .rdata(mid_q)
  );

  hng_ram #(.WIDTH(H_W), .DEPTH(MAX_ROW_WIDTH)) u_up_ram (
    .clk  (clk),
    .we   (cmd.wr_en && !y_is0),
    .waddr(x_r),
    .wdata(rd_a_r),
    .re   (cmd.rd_en),
    .raddr(raddr),
    .rdata(up_q)
  );

  always_ff @(posedge clk) begin
    if (cmd.cap_en) begin
      case (cmd.cap_step)
        RD_CUR: begin
          rd_a_r <= mid_q;
          rd_f_r <= up_q;
        end
        RD_NEXT:  rd_b_r <= mid_q;
        RD_PREV: begin
          rd_c_r <= mid_q;
          rd_e_r <= up_q;
        end
        RD_PREV2: rd_d_r <= mid_q;
        default:  rd_d_r <= mid_q;
      endcase
    end
  end

  // ---------------- vertex neighborhood
  logic signed [H_W-1:0] smp_s, e_c, e_l, e_r, e_up, e_dn;
  logic        [31:0]    e_col, e_row;
  logic signed [H_W:0]   dx, dz;
  logic        [H_W:0]   dx_abs, dz_abs;

  assign smp_s = smp_r;

  always_comb begin
    case (cmd.emit_sel)
      EMIT_BELOW: begin
        e_col = 32'(x_r);
        e_row = 32'(y_r) - 32'd1;
        e_c   = rd_a_r;
        e_l   = x_gt0 ? rd_e_r : rd_a_r;
        e_r   = has_right ? rd_b_r : rd_a_r;
        e_up  = y_is1 ? rd_a_r : rd_f_r;
        e_dn  = smp_s;
      end
      EMIT_LEFT: begin
        e_col = 32'(x_r) - 32'd1;
        e_row = 32'(y_r);
        e_c   = rd_c_r;
        e_l   = x_ge2 ? rd_d_r : rd_c_r;
        e_r   = smp_s;
        e_up  = y_is0 ? rd_c_r : rd_e_r;
        e_dn  = rd_c_r;
      end
      default: begin
        // last point of the frame: above is the just-rotated middle row entry
        e_col = 32'(x_r);
        e_row = 32'(y_r);
        e_c   = smp_s;
        e_l   = x_gt0 ? rd_c_r : smp_s;
        e_r   = smp_s;
        e_up  = y_is0 ? smp_s : rd_a_r;
        e_dn  = smp_s;
      end
    endcase
  end

  assign dx     = {e_l[H_W-1], e_l} - {e_r[H_W-1], e_r};
  assign dz     = {e_up[H_W-1], e_up} - {e_dn[H_W-1], e_dn};
  assign dx_abs = dx[H_W] ? (H_W+1)'(-dx) : dx;
  assign dz_abs = dz[H_W] ? (H_W+1)'(-dz) : dz;

  logic [COL_W-1:0] col_r;
  logic [ROW_W-1:0] row_r;
  logic [H_W-1:0]   hgt_r;
  logic [H_W-1:0]   mx_r, mz_r;
  logic             sx_r, sz_r, last_r;

  always_ff @(posedge clk) begin
    if (cmd.load_emit) begin
      col_r  <= e_col[COL_W-1:0];
      row_r  <= e_row[ROW_W-1:0];
      hgt_r  <= e_c;
      mx_r   <= dx_abs[H_W-1:0];
      mz_r   <= dz_abs[H_W-1:0];
      sx_r   <= dx[H_W];
      sz_r   <= dz[H_W];
      last_r <= (cmd.emit_sel == EMIT_LAST);
    end
  end

  // ---------------- squares and sum
  logic [H_W-1:0]   mul_in;
  logic [2*H_W-1:0] mul_out, sqx_r, sqz_r;
  logic [SUM_W-1:0] s_r;

  assign mul_in  = cmd.sq_z ? mz_r : mx_r;
  assign mul_out = mul_in * mul_in;

  always_ff @(posedge clk) begin
    if (cmd.sq_x) begin
      sqx_r <= mul_out;
    end
    if (cmd.sq_z) begin
      sqz_r <= mul_out;
    end
    if (cmd.sum) begin
      s_r <= SUM_W'(sqx_r) + SUM_W'(sqz_r) + TWO_SQ;
    end
  end

  // ---------------- q = floor(2^30 m^2 / S), restoring, one bit a cycle
  logic [2*H_W-1:0] msq;
  logic [SUM_W-1:0] rem_r;
  logic             dvd_bit_r;
  logic [30:0]      quo_r;
  logic [SUM_W:0]   trial;
  logic             ge;

  always_comb begin
    case (cmd.comp)
      COMP_X:  msq = sqx_r;
      COMP_Y:  msq = TWO_SQ[2*H_W-1:0];
      COMP_Z:  msq = sqz_r;
      default: msq = sqz_r;
    endcase
  end

  assign trial = {rem_r, dvd_bit_r};
  assign ge    = (trial >= {1'b0, s_r});

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      rem_r     <= SUM_W'(msq[2*H_W-1:1]);
      dvd_bit_r <= msq[0];
      quo_r     <= '0;
    end else if (cmd.div_step) begin
      dvd_bit_r <= 1'b0;
      quo_r     <= {quo_r[29:0], ge};
      if (ge) begin
        rem_r <= SUM_W'(trial - {1'b0, s_r});
      end else begin
        rem_r <= trial[SUM_W-1:0];
      end
    end
  end

  // ---------------- r = isqrt(q), two bits of q a cycle; value = (r + 1) / 2
  logic [30:0] num_r;
  logic [31:0] res_r, bit_r, rb_sum;
  logic [16:0] rnd;
  logic [15:0] mag;

  assign rb_sum = res_r + bit_r;

  always_ff @(posedge clk) begin
    if (cmd.sqrt_init) begin
      num_r <= quo_r;
      res_r <= '0;
      bit_r <= 32'h4000_0000;
    end else if (cmd.sqrt_step) begin
      bit_r <= bit_r >> 2;
      if ({1'b0, num_r} >= rb_sum) begin
        num_r <= num_r - rb_sum[30:0];
        res_r <= (res_r >> 1) + bit_r;
      end else begin
        res_r <= res_r >> 1;
      end
    end
  end

  assign rnd = {1'b0, res_r[15:0]} + 17'd1;
  assign mag = rnd[16:1];

  logic [N_W-1:0]  nx_r, nz_r;
  logic [NY_W-1:0] ny_r;

  always_ff @(posedge clk) begin
    if (cmd.store) begin
      case (cmd.comp)
        COMP_X:  nx_r <= sx_r ? N_W'(-mag) : mag;
        COMP_Y:  ny_r <= mag[NY_W-1:0];
        default: nz_r <= sz_r ? N_W'(-mag) : mag;
      endcase
    end
  end

  // ---------------- output register
  logic                  out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic                  out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data_r <= {3'b000, nz_r, ny_r, nx_r, hgt_r, row_r, col_r};
      out_last_r <= last_r;
    end
  end

  assign stat.out_busy = out_valid_r;
  assign out_valid     = out_valid_r;
  assign out_data      = out_data_r;
  assign out_last      = out_last_r;

  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_step |-> (rem_r < s_r)) else $error("divider remainder out of range");
  a_root_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.store |-> (res_r <= 32'd32768)) else $error("root exceeds unit length");
  a_left_col: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.load_emit && cmd.emit_sel == EMIT_LEFT) |-> x_gt0)
    else $error("left vertex at column zero");

endmodule
`default_nettype wire

// File: sv/heightmap_normal_generator_core.sv
`default_nettype none
// Heightmap to normal-map generator.
//
// in_*  : height samples of one frame in raster order (signed Q8.8), one per
//         request. Frame geometry comes from the cfg_* APB registers:
//         0x0 row_width, 0x4 row_count (0 acts as 1, larger than the
//         maximum acts as the maximum). Write them only while idle.
// out_* : one request per vertex: column, row, height and the unit normal
//         (Q1.14) of (left-right, 2.0, above-below). A vertex leaves once
//         the sample below it arrives; on the last row each sample also
//         releases the vertex to its left, and the final sample releases
//         its own vertex with out_tlast set.
// Timing: one sample at a time. A sample passes through the store reads
//         and the store write, then through the shared normalizer once
//         per vertex it releases (0 to 3): squares and sum, then per
//         component a 31-step restoring divider and a 16-step integer
//         square root, three components per vertex.
// Stall:  results sit in an output register; while out_tready is low the
//         normalizer finishes the next vertex and then waits for the slot.
// Reset:  counters go to the frame start, registers to 1024, out_tvalid low.
//         Row stores are not cleared; every entry is written before use.
module heightmap_normal_generator_core #(
  parameter int MAX_ROW_WIDTH = hng_pkg::DEF_MAX_ROW_WIDTH,
  parameter int MAX_ROW_COUNT = hng_pkg::DEF_MAX_ROW_COUNT
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,     // [15:0] height_sample
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [87:0]      out_tdata,    // [9:0] column, [21:10] row, [37:22] height_out,
                                         // [53:38] normal_x, [68:54] normal_y,
                                         // [84:69] normal_z, [87:85] zero
  output logic             out_tlast,    // frame_last
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);
  import hng_pkg::*;

  logic [CFG_RW_W-1:0] row_width_r;
  logic [CFG_RC_W-1:0] row_count_r;
  logic                cfg_wr;

  // APB: zero wait states, write lands on the access phase
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_width_r <= RST_ROW_WIDTH;
      row_count_r <= RST_ROW_COUNT;
    end else if (cfg_wr) begin
      if (cfg_paddr[2] == REG_ROW_WIDTH) begin
        row_width_r <= cfg_pwdata[CFG_RW_W-1:0];
      end else begin
        row_count_r <= cfg_pwdata[CFG_RC_W-1:0];
      end
    end
  end

  assign cfg_prdata = (cfg_paddr[2] == REG_ROW_COUNT) ? 32'(row_count_r)
                                                      : 32'(row_width_r);

  hng_cmd_t  cmd;
  hng_stat_t stat;

  hng_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  hng_dp #(
    .MAX_ROW_WIDTH(MAX_ROW_WIDTH),
    .MAX_ROW_COUNT(MAX_ROW_COUNT)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .stat     (stat),
    .row_width(row_width_r),
    .row_count(row_count_r),
    .sample   (in_tdata),
    .out_valid(out_tvalid),
    .out_ready(out_tready),
    .out_data (out_tdata),
    .out_last (out_tlast)
  );

endmodule
`default_nettype wire
